// ===== src/stbx_pkg.sv =====
`timescale 1ns / 1ps

package stbx_pkg;

   // Quality level codes. Codes above LEVEL_MONO_SIX behave like it.
   localparam logic [2:0] LEVEL_STEREO    = 3'd0;
   localparam logic [2:0] LEVEL_MONO_ONE  = 3'd1;
   localparam logic [2:0] LEVEL_MONO_TWO  = 3'd2;
   localparam logic [2:0] LEVEL_MONO_THREE = 3'd3;
   localparam logic [2:0] LEVEL_MONO_SIX  = 3'd4;

   // Reciprocal of three scaled by two to the RECIP_SHIFT, rounded up.
   // Exact for magnitudes below 2^19, and the datapath stays below 2^17.
   localparam int unsigned RECIP_SHIFT = 20;
   localparam logic [18:0] RECIP_THREE = 19'd349526;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   // One stereo frame on the request channel.
   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
   } req_payload_type;

   // One averaged frame on the result channel.
   typedef struct packed {
      logic signed [15:0] first_sample;
      logic signed [15:0] second_sample;
      logic               is_mono;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accumulate;
      logic clear;
      logic capture;
      logic divide;
      logic load_out;
      logic mono;
      logic shift_two;
      logic div_three;
   } stbx_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_ready;
   } stbx_status_type;

endpackage

// ===== src/stbx_datapath.sv =====
`timescale 1ns / 1ps

module stbx_datapath import stbx_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  stbx_cmd_type    cmd,
   output stbx_status_type status,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic signed [18:0] acc_left_ff, acc_left_in;
   logic signed [18:0] acc_right_ff, acc_right_in;
   logic        [16:0] mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic        [16:0] quot_ff, quot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic signed [19:0] mono_sum;
   logic        [19:0] mono_mag;
   logic        [19:0] mono_shifted;
   logic        [35:0] product;
   logic signed [17:0] mono_value;

   // Clamp a wide signed value to the 16-bit sample range.
   function automatic logic signed [15:0] sat19(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v > 19'(SAMPLE_MAX)) begin
         r = SAMPLE_MAX;
      end else if (v < 19'(SAMPLE_MIN)) begin
         r = SAMPLE_MIN;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Accumulators: cleared after each output frame and on a level write.
   always_comb begin
      acc_left_in  = acc_left_ff;
      acc_right_in = acc_right_ff;
      if (cmd.clear) begin
         acc_left_in  = '0;
         acc_right_in = '0;
      end else if (cmd.accumulate) begin
         acc_left_in  = acc_left_ff + 19'(req_payload.left_sample);
         acc_right_in = acc_right_ff + 19'(req_payload.right_sample);
      end
   end

   // Mono sum split into sign and magnitude so that the divide truncates toward zero.
   always_comb begin
      mono_sum     = 20'(acc_left_ff) + 20'(acc_right_ff);
      mono_mag     = mono_sum[19] ? 20'(-mono_sum) : 20'(mono_sum);
      mono_shifted = cmd.shift_two ? (mono_mag >> 2) : (mono_mag >> 1);
      mag_in       = cmd.capture ? mono_shifted[16:0] : mag_ff;
      neg_in       = cmd.capture ? mono_sum[19] : neg_ff;
   end

   // Divide by three through a reciprocal multiply where the factor needs it.
   always_comb begin
      product = 36'(mag_ff) * 36'(RECIP_THREE);
      quot_in = quot_ff;
      if (cmd.divide) begin
         quot_in = cmd.div_three ? {1'b0, product[RECIP_SHIFT +: 16]} : mag_ff;
      end
   end

   // Output register: loaded only when empty or being drained.
   always_comb begin
      mono_value     = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         if (cmd.mono) begin
            rsp_payload_in.first_sample  = sat19(19'(mono_value));
            rsp_payload_in.second_sample = '0;
            rsp_payload_in.is_mono       = 1'b1;
         end else begin
            rsp_payload_in.first_sample  = sat19(acc_left_ff);
            rsp_payload_in.second_sample = sat19(acc_right_ff);
            rsp_payload_in.is_mono       = 1'b0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_left_ff  <= '0;
         acc_right_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_left_ff  <= acc_left_in;
         acc_right_ff <= acc_right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      quot_ff        <= quot_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign status.out_ready = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_payload_ff;

endmodule

// ===== src/stbx_controller.sv =====
`timescale 1ns / 1ps

module stbx_controller import stbx_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            csr_write_enable,
   input  logic [2:0]      csr_write_data,
   input  stbx_status_type status,
   output stbx_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SUM   = 4'b0010,
      ST_MULT  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] level_ff, level_in;
   logic [2:0] count_ff, count_in;
   logic [2:0] factor;
   logic       accept;
   logic       last_frame;

   // Decode the quality level into the decimation factor.
   always_comb begin
      unique case (level_ff) inside
         LEVEL_STEREO, LEVEL_MONO_ONE: factor = 3'd1;
         LEVEL_MONO_TWO:               factor = 3'd2;
         LEVEL_MONO_THREE:             factor = 3'd3;
         default:                      factor = 3'd6;
      endcase
   end

   assign accept     = req_valid && (state_ff == ST_IDLE) && !csr_write_enable;
   assign last_frame = (count_ff + 3'd1) == factor;

   // Sequencer: accumulate in idle, then sum, divide and write one frame.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      level_in       = csr_write_enable ? csr_write_data : level_ff;
      cmd            = '0;
      cmd.mono       = level_ff != LEVEL_STEREO;
      cmd.shift_two  = (factor == 3'd2) || (factor == 3'd6);
      cmd.div_three  = (factor == 3'd3) || (factor == 3'd6);
      if (csr_write_enable) begin
         cmd.clear = 1'b1;
         count_in  = '0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accumulate = 1'b1;
               if (last_frame) begin
                  count_in = '0;
                  state_in = ST_SUM;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
         end
         ST_SUM: begin
            cmd.capture = 1'b1;
            state_in    = ST_MULT;
         end
         ST_MULT: begin
            cmd.divide = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_ready) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= LEVEL_STEREO;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

   // A level write takes the cycle, so no request is taken alongside it.
   assign req_stall = (state_ff != ST_IDLE) || csr_write_enable;

   // The frame count never reaches the decimation factor between outputs.
   a_count_below_factor: assert property (@(posedge clock) disable iff (reset)
      count_ff < factor)
      else $error("frame count reached the decimation factor");

   // The request that completes a frame starts the output sequence.
   a_last_starts_sum: assert property (@(posedge clock) disable iff (reset)
      accept && last_frame |=> state_ff == ST_SUM)
      else $error("completed frame did not start the sum step");

   // The multiply step always follows the sum step.
   a_sum_to_mult: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |=> state_ff == ST_MULT)
      else $error("sum step not followed by multiply step");

   // The output register is never loaded while a result waits in it.
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_ready)
      else $error("output loaded while a stalled result is held");

endmodule

// ===== src/stereo_boxcar_decimator_unit.sv =====
`timescale 1ns / 1ps

// Boxcar-average decimator with optional mono downmix.
// Request channel (req_valid, req_stall, req_payload) carries one stereo frame.
// Result channel (rsp_valid, rsp_stall, rsp_payload) carries one averaged frame.
// csr_write_enable writes the 3-bit quality level and clears the frame count and
// both accumulators; write it only while the block is idle. req_stall is high
// during the write cycle.
// Requests that do not complete a frame group stream at one per cycle while no
// level write stalls them. After the request that completes a group, req_stall
// stays high while the controller steps the datapath through sum, reciprocal
// multiply and output write; the output write waits while a stalled result
// holds the output register, and rsp_valid rises when it loads. No request is
// taken until that three-step divide sequence has finished.
// A result waits in the output register while rsp_stall is high; meanwhile new
// requests are still accepted, and only the next completed group waits.
// Synchronous reset sets quality level zero (factor one, stereo), clears the
// count and accumulators and empties the output register.

module stereo_boxcar_decimator_unit import stbx_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [2:0]      csr_write_data
);

   stbx_cmd_type    cmd;
   stbx_status_type status;

   // Sequencer for level, frame count and output steps.
   stbx_controller u_controller (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .cmd              (cmd)
   );

   // Accumulators, divider and output register.
   stbx_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
